// File: rtl/srb_pkg.sv
`timescale 1ns / 1ps

package srb_pkg;

  localparam int IDX_W   = 32;
  localparam int BYTE_W  = 8;
  localparam int SPACE_W = 7;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PROC,
    ST_READ,
    ST_EMIT,
    ST_CLOSE
  } state_e;

  // Request from the controller to load the output register.
  typedef struct packed {
    logic load;
    logic has_byte;
    logic closed;
    logic last;
  } emit_t;

endpackage

// File: rtl/srb_mem.sv
`timescale 1ns / 1ps

module srb_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6,
  parameter int DW    = 8
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/srb_ctrl.sv
`timescale 1ns / 1ps

module srb_ctrl import srb_pkg::*; #(
  parameter int CAPACITY = 64,
  parameter int SW       = 6
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [IDX_W-1:0]   byte_index_i,
  input  logic [BYTE_W-1:0]  byte_value_i,
  input  logic               has_byte_i,
  input  logic               segment_end_i,
  input  logic               final_segment_i,
  input  logic [SPACE_W-1:0] free_space_i,
  input  logic               out_free_i,
  output emit_t              emit_o,
  output logic               ram_we_o,
  output logic [SW-1:0]      ram_waddr_o,
  output logic [BYTE_W-1:0]  ram_wdata_o,
  output logic               ram_re_o,
  output logic [SW-1:0]      ram_raddr_o
);

  state_e state_q, state_d;

  // Captured input beat.
  logic [IDX_W-1:0]   idx_q;
  logic [BYTE_W-1:0]  val_q;
  logic               has_q;
  logic               seg_q;
  logic               fin_q;
  logic [SPACE_W-1:0] space_q;

  // Stream state.
  logic [IDX_W-1:0]    next_q;
  logic [IDX_W-1:0]    final_q;
  logic                known_q;
  logic                closed_q;
  logic [SW-1:0]       rs_q;
  logic [CAPACITY-1:0] valid_q;

  // Flags of the byte whose read is in flight.
  logic ends_q;
  logic last_q;

  logic [IDX_W-1:0] off;
  logic             in_win;
  logic [SW:0]      sum;
  logic [SW-1:0]    slot;
  logic             store_en;
  logic             empty_close;
  logic [SW-1:0]    rs_next;
  logic             ends;
  logic             drain_last;

  always_comb begin
    off    = idx_q - next_q;
    in_win = (off < {{(IDX_W-SPACE_W){1'b0}}, space_q}) && (off < IDX_W'(CAPACITY));
    sum    = {1'b0, rs_q} + off[SW:0];
    if (sum >= (SW+1)'(CAPACITY)) begin
      slot = SW'(sum - (SW+1)'(CAPACITY));
    end else begin
      slot = sum[SW-1:0];
    end
    store_en    = (state_q == ST_PROC) && has_q && in_win && !valid_q[slot];
    empty_close = !has_q && fin_q && (idx_q == next_q);
    rs_next     = (rs_q == SW'(CAPACITY-1)) ? '0 : rs_q + 1'b1;
    ends        = known_q && (next_q == final_q);
    drain_last  = ends || !valid_q[rs_next];
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i && !closed_q) state_d = ST_PROC;
      end
      ST_PROC: begin
        if (empty_close) state_d = ST_CLOSE;
        else if (seg_q)  state_d = ST_READ;
        else             state_d = ST_IDLE;
      end
      ST_READ: begin
        state_d = valid_q[rs_q] ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (out_free_i) state_d = last_q ? ST_IDLE : ST_READ;
      end
      ST_CLOSE: begin
        if (out_free_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    in_ready_o      = (state_q == ST_IDLE);
    ram_we_o        = store_en;
    ram_waddr_o     = slot;
    ram_wdata_o     = val_q;
    ram_re_o        = (state_q == ST_READ) && valid_q[rs_q];
    ram_raddr_o     = rs_q;
    emit_o.load     = ((state_q == ST_EMIT) || (state_q == ST_CLOSE)) && out_free_i;
    emit_o.has_byte = (state_q == ST_EMIT);
    emit_o.closed   = (state_q == ST_EMIT) ? ends_q : 1'b1;
    emit_o.last     = (state_q == ST_EMIT) ? last_q : 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      next_q   <= '0;
      final_q  <= '0;
      known_q  <= 1'b0;
      closed_q <= 1'b0;
      rs_q     <= '0;
      valid_q  <= '0;
      ends_q   <= 1'b0;
      last_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_PROC) begin
        if (fin_q && has_q) begin
          final_q <= idx_q;
          known_q <= 1'b1;
        end else if (fin_q && !empty_close) begin
          final_q <= idx_q - 32'd1;
          known_q <= 1'b1;
        end
        if (empty_close) closed_q <= 1'b1;
        if (store_en) valid_q[slot] <= 1'b1;
      end
      if ((state_q == ST_READ) && valid_q[rs_q]) begin
        valid_q[rs_q] <= 1'b0;
        rs_q          <= rs_next;
        next_q        <= next_q + 32'd1;
        ends_q        <= ends;
        last_q        <= drain_last;
        if (ends) closed_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && (state_q == ST_IDLE)) begin
      idx_q   <= byte_index_i;
      val_q   <= byte_value_i;
      has_q   <= has_byte_i;
      seg_q   <= segment_end_i;
      fin_q   <= final_segment_i;
      space_q <= free_space_i;
    end
  end

endmodule

// File: rtl/stream_byte_reassembler.sv
`timescale 1ns / 1ps

// In-order byte stream reassembler.
// The input channel takes one beat per byte, tagged with its absolute stream
// index; a beat with has_byte_i low marks an empty segment. Bytes less than
// min(free_space_i, CAPACITY) past the next expected index are kept in a
// circular byte memory with a valid bit per entry; others are dropped.
// A beat with segment_end_i high drains every contiguous stored byte in order on
// the output channel, one result beat per byte, with run_last_o on the last one.
// A beat that drains nothing is accepted, then updates the store. A drain that
// finds the head entry empty adds a step to look at it. Otherwise each byte
// goes through the read-modify-write loop around the byte memory (head check
// with read issue, then the registered read data loads the output register),
// and the last byte goes straight back to accepting.
// The input channel is ready only between beats; the output register lets a new
// input beat be accepted while the last result still waits to be taken.
// If the receiver stalls, the drain holds at the output register and resumes when
// it is taken. Once the stream closes, input beats are accepted and ignored.
// Reset clears the valid bits, indices and flags at once; no clearing pass is
// needed, and the byte memory itself is never reset.
module stream_byte_reassembler import srb_pkg::*; #(
  parameter int CAPACITY = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [IDX_W-1:0]   byte_index_i,
  input  logic [BYTE_W-1:0]  byte_value_i,
  input  logic               has_byte_i,
  input  logic               segment_end_i,
  input  logic               final_segment_i,
  input  logic [SPACE_W-1:0] free_space_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [BYTE_W-1:0]  out_byte_o,
  output logic               out_has_byte_o,
  output logic               stream_closed_o,
  output logic               run_last_o
);

  localparam int SW = $clog2(CAPACITY);

  emit_t             emit;
  logic              out_free;
  logic              ram_we;
  logic [SW-1:0]     ram_waddr;
  logic [BYTE_W-1:0] ram_wdata;
  logic              ram_re;
  logic [SW-1:0]     ram_raddr;
  logic [BYTE_W-1:0] ram_rdata;

  // Output register.
  logic              out_valid_q;
  logic [BYTE_W-1:0] out_byte_q;
  logic              out_has_q;
  logic              out_closed_q;
  logic              out_last_q;

  // The output register can take a new result when empty or being emptied.
  assign out_free = !out_valid_q || out_ready_i;

  srb_ctrl #(
    .CAPACITY (CAPACITY),
    .SW       (SW)
  ) u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .byte_index_i    (byte_index_i),
    .byte_value_i    (byte_value_i),
    .has_byte_i      (has_byte_i),
    .segment_end_i   (segment_end_i),
    .final_segment_i (final_segment_i),
    .free_space_i    (free_space_i),
    .out_free_i      (out_free),
    .emit_o          (emit),
    .ram_we_o        (ram_we),
    .ram_waddr_o     (ram_waddr),
    .ram_wdata_o     (ram_wdata),
    .ram_re_o        (ram_re),
    .ram_raddr_o     (ram_raddr)
  );

  srb_mem #(
    .DEPTH (CAPACITY),
    .AW    (SW),
    .DW    (BYTE_W)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit.load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // An empty close result carries a zero byte.
  always_ff @(posedge clk_i) begin
    if (emit.load) begin
      out_byte_q   <= emit.has_byte ? ram_rdata : '0;
      out_has_q    <= emit.has_byte;
      out_closed_q <= emit.closed;
      out_last_q   <= emit.last;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_byte_o      = out_byte_q;
  assign out_has_byte_o  = out_has_q;
  assign stream_closed_o = out_closed_q;
  assign run_last_o      = out_last_q;

endmodule
